// ===== hdl/dcbs_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dcbs_pkg
// Shared constants, request codes and types of the disk controller bus slave.
// ---------------------------------------------------------------------------
package dcbs_pkg;

  // Sizes
  localparam int MEM_WORDS = 262144;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int MAX_CHAIN = 65535;
  localparam int CHAIN_W   = $clog2(MAX_CHAIN + 1);
  localparam int ADDR_W    = 22;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  // Disk register map
  localparam logic [ADDR_W-1:0] ADDR_STATUS = 22'h3dfff8;
  localparam logic [ADDR_W-1:0] ADDR_MA     = 22'h3dfff9;
  localparam logic [ADDR_W-1:0] ADDR_DA     = 22'h3dfffa;
  localparam logic [ADDR_W-1:0] ADDR_ECC    = 22'h3dfffb;
  localparam logic [ADDR_W-1:0] ADDR_CMD    = 22'h3dfffc;
  localparam logic [ADDR_W-1:0] ADDR_CLP    = 22'h3dfffd;
  localparam logic [ADDR_W-1:0] ADDR_DA2    = 22'h3dfffe;
  localparam logic [ADDR_W-1:0] ADDR_START  = 22'h3dffff;

  // Bus function code
  localparam logic FUNC_READ = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTORS    = 1'b1;

  // Command opcode field (low 10 bits); zero means disk read
  localparam int CMD_W = 10;
  localparam logic [CMD_W-1:0] CMD_READ = '0;

  // Disk address fields
  localparam int UNIT_W = 3;
  localparam int CYL_W  = 12;
  localparam int HEAD_W = 8;
  localparam int BLK_W  = 8;

  // Memory address keeps only the bits above the low byte
  localparam int MA_LOW_W = 8;
  localparam int MA_W     = DATA_W - MA_LOW_W;

  // Fixed read values
  localparam logic [DATA_W-1:0] STATUS_VALUE  = 32'h0000_0001;
  localparam logic [DATA_W-1:0] ZERO_VALUE    = 32'h0000_0000;
  localparam logic [DATA_W-1:0] UNKNOWN_VALUE = 32'hffff_ffff;

  // Classified request kinds
  typedef enum logic [2:0] {
    OP_MEM_RD,
    OP_MEM_WR,
    OP_REG_RD,
    OP_CMD_WR,
    OP_CLP_WR,
    OP_DA_WR,
    OP_START
  } op_t;

  // Register read source
  typedef enum logic [2:0] {
    RS_STATUS,
    RS_MA,
    RS_DA,
    RS_ZERO,
    RS_CLP,
    RS_ONES
  } reg_sel_t;

  // One classified request in the queue
  typedef struct packed {
    op_t                op;
    reg_sel_t           sel;
    logic [MEM_AW-1:0]  mem_addr;
    logic [DATA_W-1:0]  data;
  } req_t;

  // Command chain walker
  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_FETCH,
    WALK_CHECK
  } walk_state_t;

endpackage
`default_nettype wire

// ===== hdl/dcbs_req_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dcbs_req_if
// Bus request channel: function, word address and write data.
// ---------------------------------------------------------------------------
interface dcbs_req_if import dcbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [ADDR_W-1:0] bus_addr;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, func, bus_addr, write_data, input ready);
  modport sink   (input valid, func, bus_addr, write_data, output ready);
endinterface
`default_nettype wire

// ===== hdl/dcbs_rsp_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dcbs_rsp_if
// Bus response channel: read data of a read request.
// ---------------------------------------------------------------------------
interface dcbs_rsp_if import dcbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface
`default_nettype wire

// ===== hdl/dcbs_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dcbs_ram
// Generic memory, one write port and one read port, registered read data.
// ---------------------------------------------------------------------------
module dcbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dcbs_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dcbs_front
// Takes bus requests, decodes the address and queues the work to do.
// ---------------------------------------------------------------------------
module dcbs_front import dcbs_pkg::*; (
  dcbs_req_if.sink req,
  output logic     q_valid,
  input  logic     q_ready,
  output req_t     q_data
);

  logic is_mem;
  logic keep;

  assign is_mem = (req.bus_addr < ADDR_W'(MEM_WORDS));

  // Address decode; ignored writes are accepted and dropped here
  always_comb begin
    q_data.op       = OP_REG_RD;
    q_data.sel      = RS_ONES;
    q_data.mem_addr = req.bus_addr[MEM_AW-1:0];
    q_data.data     = req.write_data;
    keep            = 1'b1;
    if (is_mem) begin
      q_data.op = (req.func == FUNC_READ) ? OP_MEM_RD : OP_MEM_WR;
    end else if (req.func == FUNC_READ) begin
      case (req.bus_addr)
        ADDR_STATUS, ADDR_CMD: q_data.sel = RS_STATUS;
        ADDR_MA:               q_data.sel = RS_MA;
        ADDR_DA, ADDR_DA2:     q_data.sel = RS_DA;
        ADDR_ECC, ADDR_START:  q_data.sel = RS_ZERO;
        ADDR_CLP:              q_data.sel = RS_CLP;
        default:               q_data.sel = RS_ONES;
      endcase
    end else begin
      case (req.bus_addr)
        ADDR_CMD:   q_data.op = OP_CMD_WR;
        ADDR_CLP:   q_data.op = OP_CLP_WR;
        ADDR_DA2:   q_data.op = OP_DA_WR;
        ADDR_START: q_data.op = OP_START;
        default:    keep = 1'b0;
      endcase
    end
  end

  assign q_valid   = req.valid && keep;
  assign req.ready = q_ready;

endmodule
`default_nettype wire

// ===== hdl/dcbs_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dcbs_queue
// Short request queue between the decode front and the execute back.
// ---------------------------------------------------------------------------
module dcbs_queue import dcbs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  req_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output req_t pop_data
);

  req_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;
  logic               push;
  logic               pop;

  assign push_ready = (count != (Q_PTR_W + 1)'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dcbs_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dcbs_back
// Executes queued requests: word memory, disk registers, the command chain
// walk, and the response register.
// ---------------------------------------------------------------------------
module dcbs_back import dcbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  req_t                 q_data,
  dcbs_rsp_if.source           rsp
);

  // Geometry
  logic [CFG_W-1:0] head_count;
  logic [CFG_W-1:0] sectors_per_track;

  // Disk registers
  logic [CMD_W-1:0]  command_reg;
  logic [DATA_W-1:0] list_pointer;
  logic [DATA_W-1:0] disk_address;
  logic [MA_W-1:0]   memory_address;

  // Walk working position
  logic [UNIT_W-1:0]  unit;
  logic [CYL_W-1:0]   cyl;
  logic [HEAD_W-1:0]  head;
  logic [BLK_W-1:0]   blk;
  logic [CHAIN_W-1:0] chain_count;

  walk_state_t state, state_next;

  // Response stage
  logic              s1_valid;
  logic              s1_mem;
  logic [DATA_W-1:0] s1_data;

  // Memory port
  logic              ram_we;
  logic              ram_re;
  logic [MEM_AW-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              busy;
  logic              pop;
  logic              is_read_op;
  logic              start_walk;
  logic              ptr_out;
  logic              chain_last;
  logic              walk_done;
  logic [DATA_W-1:0] reg_value;

  logic [BLK_W:0]     blk_inc;
  logic [HEAD_W:0]    head_inc;
  logic               blk_wrap;
  logic               head_wrap;
  logic [BLK_W-1:0]   blk_new;
  logic [HEAD_W-1:0]  head_new;
  logic [CYL_W-1:0]   cyl_new;
  logic [DATA_W-1:0]  repack_da;

  dcbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_data.mem_addr),
    .wdata (q_data.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Issue control: reads need room in the response stage, a start needs
  // the response stage empty so the walk may reuse the read port
  assign busy       = (state != WALK_IDLE);
  assign is_read_op = (q_data.op == OP_MEM_RD) || (q_data.op == OP_REG_RD);

  always_comb begin
    if (busy) begin
      q_ready = 1'b0;
    end else if (is_read_op) begin
      q_ready = !s1_valid || rsp.ready;
    end else if (q_data.op == OP_START) begin
      q_ready = !s1_valid;
    end else begin
      q_ready = 1'b1;
    end
  end

  assign pop        = q_valid && q_ready;
  assign ram_we     = pop && (q_data.op == OP_MEM_WR);
  assign start_walk = pop && (q_data.op == OP_START) && (command_reg == CMD_READ);
  assign ptr_out    = (list_pointer >= DATA_W'(MEM_WORDS));
  assign chain_last = (chain_count == CHAIN_W'(MAX_CHAIN - 1));

  // Register read source
  always_comb begin
    case (q_data.sel)
      RS_STATUS: reg_value = STATUS_VALUE;
      RS_MA:     reg_value = {memory_address, {MA_LOW_W{1'b0}}};
      RS_DA:     reg_value = disk_address;
      RS_ZERO:   reg_value = ZERO_VALUE;
      RS_CLP:    reg_value = list_pointer;
      RS_ONES:   reg_value = UNKNOWN_VALUE;
      default:   reg_value = UNKNOWN_VALUE;
    endcase
  end

  // Block, head, cylinder advance
  always_comb begin
    blk_inc   = {1'b0, blk} + 1'b1;
    blk_wrap  = (blk_inc >= {1'b0, sectors_per_track});
    blk_new   = blk_wrap ? '0 : blk_inc[BLK_W-1:0];
    head_inc  = {1'b0, head} + 1'b1;
    head_wrap = blk_wrap && (head_inc >= {1'b0, head_count});
    if (!blk_wrap) begin
      head_new = head;
    end else if (head_wrap) begin
      head_new = '0;
    end else begin
      head_new = head_inc[HEAD_W-1:0];
    end
    cyl_new   = head_wrap ? cyl + 1'b1 : cyl;
    if (ram_rdata[0]) begin
      repack_da = {1'b0, unit, cyl_new, head_new, blk_new};
    end else begin
      repack_da = {1'b0, unit, cyl, head, blk};
    end
  end

  // Walk next state
  always_comb begin
    state_next = state;
    case (state)
      WALK_IDLE: begin
        if (start_walk) begin
          state_next = WALK_FETCH;
        end
      end
      WALK_FETCH: begin
        state_next = ptr_out ? WALK_IDLE : WALK_CHECK;
      end
      WALK_CHECK: begin
        if (!ram_rdata[0] || chain_last) begin
          state_next = WALK_IDLE;
        end else begin
          state_next = WALK_FETCH;
        end
      end
      default: state_next = WALK_IDLE;
    endcase
  end

  // Walk outputs: memory read port and repack strobe
  always_comb begin
    ram_re    = pop && (q_data.op == OP_MEM_RD);
    ram_raddr = q_data.mem_addr;
    walk_done = 1'b0;
    case (state)
      WALK_FETCH: begin
        ram_re    = !ptr_out;
        ram_raddr = list_pointer[MEM_AW-1:0];
      end
      WALK_CHECK: begin
        walk_done = !ram_rdata[0] || chain_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= WALK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration and disk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_count        <= '0;
      sectors_per_track <= '0;
      command_reg       <= '0;
      list_pointer      <= '0;
      disk_address      <= '0;
      memory_address    <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_HEAD_COUNT: head_count        <= cfg_wdata;
          CFG_SECTORS:    sectors_per_track <= cfg_wdata;
          default: ;
        endcase
      end
      if (pop) begin
        case (q_data.op)
          OP_CMD_WR: command_reg  <= q_data.data[CMD_W-1:0];
          OP_CLP_WR: list_pointer <= q_data.data;
          OP_DA_WR:  disk_address <= q_data.data;
          default: ;
        endcase
      end
      if (state == WALK_CHECK) begin
        memory_address <= ram_rdata[DATA_W-1:MA_LOW_W];
        if (ram_rdata[0]) begin
          list_pointer <= list_pointer + 1'b1;
        end
        if (walk_done) begin
          disk_address <= repack_da;
        end
      end
    end
  end

  // Walk working position
  always_ff @(posedge clk) begin
    if (start_walk) begin
      unit        <= disk_address[28 +: UNIT_W];
      cyl         <= disk_address[16 +: CYL_W];
      head        <= disk_address[8 +: HEAD_W];
      blk         <= disk_address[0 +: BLK_W];
      chain_count <= '0;
    end else if ((state == WALK_CHECK) && ram_rdata[0]) begin
      blk         <= blk_new;
      head        <= head_new;
      cyl         <= cyl_new;
      chain_count <= chain_count + 1'b1;
    end
  end

  // Response stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pop && is_read_op) begin
      s1_valid <= 1'b1;
    end else if (rsp.ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_read_op) begin
      s1_mem  <= (q_data.op == OP_MEM_RD);
      s1_data <= reg_value;
    end
  end

  assign rsp.valid     = s1_valid;
  assign rsp.read_data = s1_mem ? ram_rdata : s1_data;

endmodule
`default_nettype wire

// ===== hdl/disk_controller_bus_slave.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// disk_controller_bus_slave
// Word bus slave with a word memory and disk controller registers.
// ---------------------------------------------------------------------------
// Ordinary reads and writes, of memory or of registers, go at one request
// per cycle while the response side is ready and no chain walk is running;
// read data is registered through the request queue, then the registered
// memory read or the response register. A write to the start address with
// a read command stalls the bus while the command chain is walked: every
// command word fetched goes through the single read port of the memory and
// is checked in the walk state that follows. The word memory has no reset
// and no clearing pass; reading a word never written gives undefined data.
// head_count (index 0) and sectors_per_track (index 1) are written through
// the configuration port while the bus is idle; the user must keep to this, the block does not enforce it.
module disk_controller_bus_slave import dcbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  dcbs_req_if.sink             req,
  dcbs_rsp_if.source           rsp,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic f_valid;
  logic f_ready;
  req_t f_data;
  logic b_valid;
  logic b_ready;
  req_t b_data;

  dcbs_front u_front (
    .req     (req),
    .q_valid (f_valid),
    .q_ready (f_ready),
    .q_data  (f_data)
  );

  dcbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  dcbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_data    (b_data),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire
